@@ rtl/pps_pkg.sv @@
package pps_pkg;

  localparam int COORD_W   = 32;
  localparam int MAG_W     = 32;
  localparam int SQ_W      = 64;
  localparam int SUM_W     = 65;
  localparam int RAD_W     = 66;
  localparam int ROOT_W    = 33;
  localparam int QUO_W     = 31;
  localparam int PROD_W    = 63;
  localparam int SQRT_STEPS = 33;
  localparam int DIV_STEPS  = 31;
  localparam int FRAC_SH    = 30;

  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_APPEND = 2'd1;
  localparam logic [1:0] CMD_TICK   = 2'd2;

  localparam logic [1:0] REG_STEP_LENGTH  = 2'd0;
  localparam logic [1:0] REG_WIDTH_SCALE  = 2'd1;
  localparam logic [1:0] REG_HEIGHT_SCALE = 2'd2;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic               route_done;
  } out_item_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_CHECK,
    S_END,
    S_SU_RD1,
    S_SU_LATCH,
    S_SQ_X,
    S_SQ_Y,
    S_SUM,
    S_SQRT_GO,
    S_SQRT_WAIT,
    S_DIV_GO,
    S_DIV_WAIT,
    S_MUL,
    S_RND,
    S_STEP,
    S_D_MAG,
    S_D_CMP,
    S_EMIT
  } state_t;

endpackage

@@ rtl/pps_ram.sv @@
module pps_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/pps_sqrt.sv @@
module pps_sqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [pps_pkg::RAD_W-1:0]   radicand,
  output logic                        done,
  output logic [pps_pkg::ROOT_W-1:0]  root
);
  import pps_pkg::*;

  // digit-by-digit root, two radicand bits per cycle
  logic [RAD_W-1:0]  rad_r;
  logic [ROOT_W+1:0] rem_r;
  logic [ROOT_W-1:0] root_r;
  logic [5:0]        cnt_r;
  logic              busy_r, done_r;
  logic [ROOT_W+3:0] rem_sh, trial;
  logic              take;

  assign rem_sh = {rem_r, rad_r[RAD_W-1 -: 2]};
  assign trial  = {2'b00, root_r, 2'b01};
  assign take   = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 6'(SQRT_STEPS);
        rad_r  <= radicand;
        rem_r  <= '0;
        root_r <= '0;
      end else if (busy_r) begin
        rad_r  <= {rad_r[RAD_W-3:0], 2'b00};
        rem_r  <= take ? (ROOT_W+2)'(rem_sh - trial) : (ROOT_W+2)'(rem_sh);
        root_r <= {root_r[ROOT_W-2:0], take};
        cnt_r  <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

@@ rtl/pps_div.sv @@
module pps_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [pps_pkg::MAG_W-1:0]   num_mag,
  input  logic [pps_pkg::ROOT_W-1:0]  den,
  output logic                        done,
  output logic [pps_pkg::QUO_W-1:0]   quo
);
  import pps_pkg::*;

  // (num_mag << 30) / den, restoring, one quotient bit per cycle.
  // num_mag <= den, so the quotient fits in 31 bits.
  logic [ROOT_W-1:0] rem_r;
  logic [QUO_W-1:0]  sh_r;
  logic [QUO_W-1:0]  q_r;
  logic [4:0]        cnt_r;
  logic              busy_r, done_r;
  logic [ROOT_W:0]   trial;
  logic              take;

  assign trial = {rem_r, sh_r[QUO_W-1]};
  assign take  = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 5'(DIV_STEPS);
        rem_r  <= {2'b00, num_mag[MAG_W-1:1]};
        sh_r   <= {num_mag[0], {(QUO_W-1){1'b0}}};
        q_r    <= '0;
      end else if (busy_r) begin
        rem_r <= take ? ROOT_W'(trial - {1'b0, den}) : ROOT_W'(trial);
        sh_r  <= {sh_r[QUO_W-2:0], 1'b0};
        q_r   <= {q_r[QUO_W-2:0], take};
        cnt_r <= cnt_r - 5'd1;
        if (cnt_r == 5'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = q_r;

endmodule

@@ rtl/polyline_position_stepper_unit.sv @@
// Polyline position stepper.
// Input channel (in_valid/in_ready/in_data): command clear, append or tick.
// Clear and append return nothing. Append scales the point
// by width_scale/height_scale into Q16.16 and writes it into the waypoint RAM;
// appends past MAX_WAYPOINTS are dropped. A tick returns one transaction on
// the output channel (out_valid/out_ready/out_data): new position and
// route_done.
// A tick that starts a new segment also takes a square root and, for a
// segment of nonzero length, two divisions, all through one shared root
// unit and one divider, plus the RAM reads (registered read).
// Configuration writes (cfg_we/cfg_index/cfg_data) take effect at once.
// Reset (synchronous, active low) empties the route and restores the
// register defaults; the RAM content is not cleared.
// A finished result sits in the output register while the next command is
// taken; a tick that finishes while the receiver still stalls waits for it.
module polyline_position_stepper_unit #(
  parameter int MAX_WAYPOINTS = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  pps_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output pps_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import pps_pkg::*;

  localparam int AW = $clog2(MAX_WAYPOINTS);
  localparam int CW = $clog2(MAX_WAYPOINTS + 1);

  function automatic logic signed [31:0] sat41(input logic signed [40:0] v);
    if (v[40:31] == {10{v[40]}}) return v[31:0];
    return v[40] ? 32'sh80000000 : 32'sh7fffffff;
  endfunction

  function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
    if (v[32] == v[31]) return v[31:0];
    return v[32] ? 32'sh80000000 : 32'sh7fffffff;
  endfunction

  function automatic logic [MAG_W:0] absdiff(input logic signed [31:0] a,
                                             input logic signed [31:0] b);
    logic signed [32:0] d;
    logic [32:0]        n;
    d = 33'(a) - 33'(b);
    n = 33'(-d);
    return {d[32], d[32] ? n[31:0] : d[31:0]};
  endfunction

  state_t state_r, state_nxt;

  logic [31:0] step_length_r;
  logic [15:0] width_scale_r, height_scale_r;

  logic [CW-1:0] count_r;
  logic [AW-1:0] seg_r;
  logic          ready_r, done_r, phase_r, comp_r;
  logic signed [31:0] pos_x_r, pos_y_r, step_x_r, step_y_r;
  logic signed [31:0] start_x_r, start_y_r, cx_r, cy_r;
  logic [MAG_W-1:0] mag_x_r, mag_y_r;
  logic             sign_x_r, sign_y_r;
  logic [SQ_W-1:0]  sq_a_r, sq_b_r;
  logic [SUM_W-1:0] sum_r, len2_r;
  logic [ROOT_W-1:0] len_r;
  logic [QUO_W-1:0]  q_r;
  logic [PROD_W-1:0] prod_r;
  logic signed [31:0] res_x_r, res_y_r;
  logic               res_done_r;
  logic               out_valid_r;
  out_item_t          out_data_r;

  logic in_acc, full, at_end, out_load;
  logic [CW-1:0] seg_p1;
  logic [AW-1:0] seg_clamp, raddr;
  logic          ram_we;
  logic [63:0]   rdata;
  logic signed [32:0] px_prod, py_prod;
  logic signed [31:0] sx, sy, rx, ry;
  logic [MAG_W:0] ad_x, ad_y;
  logic sqrt_start, sqrt_done, div_start, div_done;
  logic [ROOT_W-1:0] root;
  logic [QUO_W-1:0]  quo;
  logic [63:0]  rnd;
  logic [33:0]  s_mag;
  logic [31:0]  m_mag;
  logic signed [31:0] step_val;
  logic [MAG_W-1:0] sq_in;

  assign in_acc = in_valid && in_ready;
  assign full   = count_r == CW'(MAX_WAYPOINTS);
  assign seg_p1 = CW'(seg_r) + CW'(1);
  assign at_end = seg_p1 >= count_r;
  assign seg_clamp = (CW'(seg_r) >= count_r) ? AW'(count_r - CW'(1)) : seg_r;

  assign px_prod = in_data.point_x * $signed({1'b0, width_scale_r});
  assign py_prod = in_data.point_y * $signed({1'b0, height_scale_r});
  assign sx = sat41({px_prod, 8'h00});
  assign sy = sat41({py_prod, 8'h00});
  assign ram_we = in_acc && in_data.command == CMD_APPEND && !full;

  assign rx = rdata[63:32];
  assign ry = rdata[31:0];

  assign ad_x = (state_r == S_SU_LATCH) ? absdiff(rx, start_x_r) : absdiff(cx_r, start_x_r);
  assign ad_y = (state_r == S_SU_LATCH) ? absdiff(ry, start_y_r) : absdiff(cy_r, start_y_r);

  assign sq_in = (state_r == S_SQ_X) ? mag_x_r : mag_y_r;

  assign rnd   = 64'(prod_r) + 64'(1 << (FRAC_SH - 1));
  assign s_mag = rnd[63:FRAC_SH];
  assign m_mag = (s_mag > 34'h07fffffff) ? 32'h7fffffff : s_mag[31:0];
  assign step_val = (comp_r ? sign_y_r : sign_x_r) ? -$signed(m_mag) : $signed(m_mag);

  pps_ram #(.WIDTH(64), .DEPTH(MAX_WAYPOINTS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count_r[AW-1:0]),
    .wdata ({sx, sy}),
    .raddr (raddr),
    .rdata (rdata)
  );

  pps_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sqrt_start),
    .radicand ({1'b0, sum_r}),
    .done     (sqrt_done),
    .root     (root)
  );

  pps_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .num_mag (comp_r ? mag_y_r : mag_x_r),
    .den     (len_r),
    .done    (div_done),
    .quo     (quo)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc && in_data.command == CMD_TICK) begin
          state_nxt = (count_r == '0) ? S_EMIT : S_CHECK;
        end
      end
      S_CHECK: begin
        if (at_end) state_nxt = S_END;
        else if (!ready_r) state_nxt = S_SU_RD1;
        else state_nxt = S_STEP;
      end
      S_END:       state_nxt = S_EMIT;
      S_SU_RD1:    state_nxt = S_SU_LATCH;
      S_SU_LATCH:  state_nxt = S_SQ_X;
      S_SQ_X:      state_nxt = S_SQ_Y;
      S_SQ_Y:      state_nxt = S_SUM;
      S_SUM:       state_nxt = phase_r ? S_D_CMP : S_SQRT_GO;
      S_SQRT_GO:   state_nxt = S_SQRT_WAIT;
      S_SQRT_WAIT: begin
        if (sqrt_done) state_nxt = (root == '0) ? S_STEP : S_DIV_GO;
      end
      S_DIV_GO:    state_nxt = S_DIV_WAIT;
      S_DIV_WAIT: begin
        if (div_done) state_nxt = S_MUL;
      end
      S_MUL:       state_nxt = S_RND;
      S_RND:       state_nxt = comp_r ? S_STEP : S_DIV_GO;
      S_STEP:      state_nxt = S_D_MAG;
      S_D_MAG:     state_nxt = S_SQ_X;
      S_D_CMP:     state_nxt = (sum_r < len2_r) ? S_EMIT : S_CHECK;
      S_EMIT: begin
        if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      end
      default:     state_nxt = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready   = state_r == S_IDLE;
    sqrt_start = state_r == S_SQRT_GO;
    div_start  = state_r == S_DIV_GO;
    out_load   = (state_r == S_EMIT) && (!out_valid_r || out_ready);
    case (state_r)
      S_CHECK:  raddr = seg_clamp;
      S_SU_RD1: raddr = seg_p1[AW-1:0];
      default:  raddr = seg_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_length_r  <= 32'h0001_0000;
      width_scale_r  <= 16'h0100;
      height_scale_r <= 16'h0100;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_STEP_LENGTH:  step_length_r  <= cfg_data;
        REG_WIDTH_SCALE:  width_scale_r  <= cfg_data[15:0];
        REG_HEIGHT_SCALE: height_scale_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= '0;
      seg_r    <= '0;
      ready_r  <= 1'b0;
      done_r   <= 1'b0;
      phase_r  <= 1'b0;
      comp_r   <= 1'b0;
      pos_x_r  <= '0;
      pos_y_r  <= '0;
      step_x_r <= '0;
      step_y_r <= '0;
      len2_r   <= '0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            case (in_data.command)
              CMD_CLEAR: begin
                count_r  <= '0;
                seg_r    <= '0;
                ready_r  <= 1'b0;
                done_r   <= 1'b0;
                pos_x_r  <= '0;
                pos_y_r  <= '0;
                step_x_r <= '0;
                step_y_r <= '0;
                len2_r   <= '0;
              end
              CMD_APPEND: begin
                if (!full) count_r <= count_r + CW'(1);
              end
              CMD_TICK: begin
                if (count_r == '0) begin
                  done_r     <= 1'b1;
                  res_x_r    <= '0;
                  res_y_r    <= '0;
                  res_done_r <= 1'b1;
                end
              end
              default: ;
            endcase
          end
        end
        S_CHECK: begin
          if (at_end) seg_r <= seg_clamp;
        end
        S_END: begin
          pos_x_r    <= rx;
          pos_y_r    <= ry;
          done_r     <= 1'b1;
          res_x_r    <= rx;
          res_y_r    <= ry;
          res_done_r <= 1'b1;
        end
        S_SU_RD1: begin
          start_x_r <= rx;
          start_y_r <= ry;
        end
        S_SU_LATCH, S_D_MAG: begin
          mag_x_r  <= ad_x[MAG_W-1:0];
          mag_y_r  <= ad_y[MAG_W-1:0];
          sign_x_r <= ad_x[MAG_W];
          sign_y_r <= ad_y[MAG_W];
          phase_r  <= state_r == S_D_MAG;
        end
        S_SQ_X: sq_a_r <= sq_in * sq_in;
        S_SQ_Y: sq_b_r <= sq_in * sq_in;
        S_SUM:  sum_r  <= SUM_W'(sq_a_r) + SUM_W'(sq_b_r);
        S_SQRT_GO: len2_r <= sum_r;
        S_SQRT_WAIT: begin
          if (sqrt_done) begin
            len_r  <= root;
            comp_r <= 1'b0;
            if (root == '0) begin
              step_x_r <= '0;
              step_y_r <= '0;
              pos_x_r  <= start_x_r;
              pos_y_r  <= start_y_r;
              ready_r  <= 1'b1;
            end
          end
        end
        S_DIV_WAIT: begin
          if (div_done) q_r <= quo;
        end
        S_MUL: prod_r <= PROD_W'(step_length_r) * PROD_W'(q_r);
        S_RND: begin
          if (comp_r) begin
            step_y_r <= step_val;
            pos_x_r  <= start_x_r;
            pos_y_r  <= start_y_r;
            ready_r  <= 1'b1;
          end else begin
            step_x_r <= step_val;
            comp_r   <= 1'b1;
          end
        end
        S_STEP: begin
          cx_r <= sat33(33'(pos_x_r) + 33'(step_x_r));
          cy_r <= sat33(33'(pos_y_r) + 33'(step_y_r));
        end
        S_D_CMP: begin
          if (sum_r < len2_r) begin
            pos_x_r    <= cx_r;
            pos_y_r    <= cy_r;
            done_r     <= 1'b0;
            res_x_r    <= cx_r;
            res_y_r    <= cy_r;
            res_done_r <= 1'b0;
          end else begin
            seg_r   <= seg_p1[AW-1:0];
            ready_r <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r.pos_x      <= res_x_r;
      out_data_r.pos_y      <= res_y_r;
      out_data_r.route_done <= res_done_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // done_r mirrors the route state; it feeds no output
  logic unused_done;
  assign unused_done = done_r;

endmodule

@@ rtl/pps_checker.sv @@
module pps_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input pps_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_ready,
  input pps_pkg::out_item_t out_data
);
  import pps_pkg::*;

  // reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result pending after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("result changed while stalled");

  // only a tick produces a result
  a_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.command != CMD_TICK |=> !$rose(out_valid))
    else $error("result without a tick");

  // a taken tick closes the input
  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.command == CMD_TICK |=> !in_ready)
    else $error("input taken during a tick");

endmodule

bind polyline_position_stepper_unit pps_checker u_pps_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
